/* src/magnetometer_minmax_calibration_macros.svh */
// Assertion macros for the magnetometer min/max calibration block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MAGNETOMETER_MINMAX_CALIBRATION_MACROS_SVH
`define MAGNETOMETER_MINMAX_CALIBRATION_MACROS_SVH

// Check cons in the same cycle as ante.
`define MMCAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define MMCAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mmcal_pkg.sv */
// Shared constants, types and sequencer states of the magnetometer calibration block.
// No dependencies.
package mmcal_pkg;

  localparam int unsigned AXES        = 3;
  localparam int unsigned SENSORS_DEF = 2;
  localparam int unsigned AXIS_W      = 2;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned DIFF_W      = 17;
  localparam int unsigned SUM_W       = 18;
  localparam int unsigned NUM_W       = 26;
  localparam int unsigned SCALED_W    = 18;
  localparam int unsigned PROD_W      = 35;
  localparam int unsigned RND_SHIFT   = 9;
  localparam int unsigned ENTRY_W     = 3 * DATA_W;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

  localparam logic signed [DATA_W-1:0] MAX_RST  = 16'sh8000;
  localparam logic signed [DATA_W-1:0] MIN_RST  = 16'sh7FFF;
  localparam logic        [DATA_W-1:0] FAC_ONE  = 16'd256;
  localparam logic        [DATA_W-1:0] FAC_CLIP = 16'hFFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] max;
    logic signed [DATA_W-1:0] min;
    logic        [DATA_W-1:0] fac;
  } entry_t;

  localparam entry_t ENTRY_RST = '{max: MAX_RST, min: MIN_RST, fac: FAC_ONE};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DIV_INIT,
    ST_DIV,
    ST_MUL,
    ST_CLIP,
    ST_DONE
  } state_e;

endpackage

/* src/mmcal_if.sv */
// Request and result channels of the magnetometer calibration block.
// Depends on mmcal_pkg for field widths.
interface mmcal_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   sensor;
  logic signed [mmcal_pkg::DATA_W-1:0]    raw_x;
  logic signed [mmcal_pkg::DATA_W-1:0]    raw_y;
  logic signed [mmcal_pkg::DATA_W-1:0]    raw_z;

  modport source (output valid, sensor, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, sensor, raw_x, raw_y, raw_z, output ready);
endinterface

interface mmcal_res_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mmcal_pkg::DATA_W-1:0]    cal_x;
  logic signed [mmcal_pkg::DATA_W-1:0]    cal_y;
  logic signed [mmcal_pkg::DATA_W-1:0]    cal_z;
  logic                                   saturated;

  modport source (output valid, cal_x, cal_y, cal_z, saturated, input ready);
  modport sink   (input valid, cal_x, cal_y, cal_z, saturated, output ready);
endinterface

/* src/magnetometer_minmax_calibration.sv */
// Channel   | dir | payload                          | handshake
// req_i     | in  | sensor, raw_x, raw_y, raw_z      | valid/ready
// res_o     | out | cal_x, cal_y, cal_z, saturated   | valid/ready
//
// A request first reads the three extents, then per axis runs the shared restoring
// divider when the axis range is nonzero, then scales and clips the axis, and
// finally hands over the result.
// Reset clears the sequencer and all entry valid bits; invalid entries read as
// reset extents and unity factor. A held result stalls only the final hand-over.
// Depends on mmcal_pkg, mmcal_if, mmcal_ram and the macros header.
`include "magnetometer_minmax_calibration_macros.svh"

module magnetometer_minmax_calibration #(
  parameter int unsigned SENSORS = mmcal_pkg::SENSORS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mmcal_req_if.sink    req_i,
  mmcal_res_if.source  res_o
);

  localparam int unsigned DEPTH = SENSORS * mmcal_pkg::AXES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(mmcal_pkg::NUM_W);
  localparam logic [AW-1:0] BASE_ONE = (SENSORS > 1) ? AW'(mmcal_pkg::AXES) : '0;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(mmcal_pkg::NUM_W - 1);

  mmcal_pkg::state_e state_q, state_d;

  logic [mmcal_pkg::AXIS_W-1:0]               axis_q;
  logic                                       sensor_q;
  logic signed [mmcal_pkg::DATA_W-1:0]        raw_q [mmcal_pkg::AXES];
  logic signed [mmcal_pkg::DATA_W-1:0]        max_q [mmcal_pkg::AXES];
  logic signed [mmcal_pkg::DATA_W-1:0]        min_q [mmcal_pkg::AXES];
  logic        [mmcal_pkg::DATA_W-1:0]        fac_q [mmcal_pkg::AXES];
  logic        [mmcal_pkg::DIFF_W-1:0]        d_q   [mmcal_pkg::AXES];
  logic signed [mmcal_pkg::DATA_W-1:0]        cal_q [mmcal_pkg::AXES];
  logic        [mmcal_pkg::SUM_W-1:0]         total_q;
  logic        [mmcal_pkg::NUM_W-1:0]         num_q;
  logic        [mmcal_pkg::SUM_W-1:0]         rem_q;
  logic        [mmcal_pkg::SUM_W-1:0]         den_q;
  logic        [CNT_W-1:0]                    div_cnt_q;
  logic signed [mmcal_pkg::PROD_W-1:0]        prod_q;
  logic                                       sat_q;
  logic                                       rd_vld_q;
  logic        [DEPTH-1:0]                    vld_q;

  logic                                       out_vld_q;
  logic signed [mmcal_pkg::DATA_W-1:0]        out_x_q, out_y_q, out_z_q;
  logic                                       out_sat_q;

  logic                        ram_we;
  logic                        load_out;
  logic                        req_ready;
  logic [AW-1:0]               ram_addr;
  logic [mmcal_pkg::ENTRY_W-1:0] ram_rdata;
  mmcal_pkg::entry_t           rd_entry;
  mmcal_pkg::entry_t           wr_entry;

  logic signed [mmcal_pkg::DATA_W-1:0] cur_raw;
  logic signed [mmcal_pkg::DATA_W-1:0] new_max, new_min;
  logic        [mmcal_pkg::DIFF_W-1:0] new_d;
  logic        [mmcal_pkg::DIFF_W-1:0] cur_d;
  logic        [mmcal_pkg::SUM_W-1:0]  den3;
  logic        [mmcal_pkg::SUM_W:0]    shifted;
  logic                                div_ge;
  logic        [mmcal_pkg::SUM_W-1:0]  rem_nxt;
  logic        [mmcal_pkg::NUM_W-1:0]  num_nxt;
  logic                                quot_clip;
  logic signed [mmcal_pkg::DIFF_W-1:0] ext_sum;
  logic signed [mmcal_pkg::SCALED_W-1:0] diff;
  logic signed [mmcal_pkg::DIFF_W-1:0] fac_s;
  logic signed [mmcal_pkg::PROD_W-1:0] prod_d;
  logic signed [mmcal_pkg::PROD_W-1:0] rnd_full;
  logic signed [mmcal_pkg::PROD_W-mmcal_pkg::RND_SHIFT-1:0] rnd;
  logic                                clip_hi, clip_lo;
  logic signed [mmcal_pkg::DATA_W-1:0] cal_d;

  // Datapath shared across axes
  always_comb begin
    ram_addr = (sensor_q ? BASE_ONE : '0) + AW'(axis_q);
    rd_entry = rd_vld_q ? mmcal_pkg::entry_t'(ram_rdata) : mmcal_pkg::ENTRY_RST;
    cur_raw  = raw_q[axis_q];
    new_max  = (cur_raw > rd_entry.max) ? cur_raw : rd_entry.max;
    new_min  = (cur_raw < rd_entry.min) ? cur_raw : rd_entry.min;
    new_d    = {new_max[mmcal_pkg::DATA_W-1], new_max} - {new_min[mmcal_pkg::DATA_W-1], new_min};

    cur_d = d_q[axis_q];
    den3  = {1'b0, cur_d} + {cur_d, 1'b0};

    shifted = {rem_q, num_q[mmcal_pkg::NUM_W-1]};
    div_ge  = shifted >= {1'b0, den_q};
    rem_nxt = div_ge ? mmcal_pkg::SUM_W'(shifted - {1'b0, den_q})
                     : shifted[mmcal_pkg::SUM_W-1:0];
    num_nxt = {num_q[mmcal_pkg::NUM_W-2:0], div_ge};
    quot_clip = |num_nxt[mmcal_pkg::NUM_W-1:mmcal_pkg::DATA_W];

    ext_sum = {max_q[axis_q][mmcal_pkg::DATA_W-1], max_q[axis_q]}
            + {min_q[axis_q][mmcal_pkg::DATA_W-1], min_q[axis_q]};
    diff    = $signed({cur_raw[mmcal_pkg::DATA_W-1], cur_raw, 1'b0})
            - $signed({ext_sum[mmcal_pkg::DIFF_W-1], ext_sum});
    fac_s   = $signed({1'b0, fac_q[axis_q]});
    prod_d  = diff * fac_s;

    rnd_full = prod_q + mmcal_pkg::PROD_W'(256);
    rnd      = rnd_full[mmcal_pkg::PROD_W-1:mmcal_pkg::RND_SHIFT];
    clip_hi  = rnd > $signed(26'sd32767);
    clip_lo  = rnd < $signed(-26'sd32768);
    cal_d    = clip_hi ? mmcal_pkg::MIN_RST
             : clip_lo ? mmcal_pkg::MAX_RST
             : rnd[mmcal_pkg::DATA_W-1:0];

    wr_entry = '{max: max_q[axis_q], min: min_q[axis_q], fac: fac_q[axis_q]};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mmcal_pkg::ST_IDLE:     if (req_i.valid) state_d = mmcal_pkg::ST_RD_ADDR;
      mmcal_pkg::ST_RD_ADDR:  state_d = mmcal_pkg::ST_RD_DATA;
      mmcal_pkg::ST_RD_DATA: begin
        state_d = (axis_q == mmcal_pkg::LAST_AXIS) ? mmcal_pkg::ST_DIV_INIT
                                                   : mmcal_pkg::ST_RD_ADDR;
      end
      mmcal_pkg::ST_DIV_INIT: begin
        state_d = (cur_d == '0) ? mmcal_pkg::ST_MUL : mmcal_pkg::ST_DIV;
      end
      mmcal_pkg::ST_DIV:      if (div_cnt_q == DIV_LAST) state_d = mmcal_pkg::ST_MUL;
      mmcal_pkg::ST_MUL:      state_d = mmcal_pkg::ST_CLIP;
      mmcal_pkg::ST_CLIP: begin
        state_d = (axis_q == mmcal_pkg::LAST_AXIS) ? mmcal_pkg::ST_DONE
                                                   : mmcal_pkg::ST_DIV_INIT;
      end
      mmcal_pkg::ST_DONE:     if (!out_vld_q || res_o.ready) state_d = mmcal_pkg::ST_IDLE;
      default:                state_d = mmcal_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_ready = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      mmcal_pkg::ST_IDLE: req_ready = 1'b1;
      mmcal_pkg::ST_CLIP: ram_we    = 1'b1;
      mmcal_pkg::ST_DONE: load_out  = !out_vld_q || res_o.ready;
      default: ;
    endcase
  end

  assign req_i.ready     = req_ready;
  assign res_o.valid     = out_vld_q;
  assign res_o.cal_x     = out_x_q;
  assign res_o.cal_y     = out_y_q;
  assign res_o.cal_z     = out_z_q;
  assign res_o.saturated = out_sat_q;

  mmcal_ram #(
    .WIDTH (mmcal_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (wr_entry),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mmcal_pkg::ST_IDLE;
      axis_q    <= '0;
      div_cnt_q <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        mmcal_pkg::ST_IDLE:     axis_q <= '0;
        mmcal_pkg::ST_RD_DATA: begin
          axis_q <= (axis_q == mmcal_pkg::LAST_AXIS) ? '0 : axis_q + 1'b1;
        end
        mmcal_pkg::ST_DIV_INIT: div_cnt_q <= '0;
        mmcal_pkg::ST_DIV:      div_cnt_q <= div_cnt_q + 1'b1;
        mmcal_pkg::ST_CLIP: begin
          vld_q[ram_addr] <= 1'b1;
          if (axis_q != mmcal_pkg::LAST_AXIS) axis_q <= axis_q + 1'b1;
        end
        default: ;
      endcase
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mmcal_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          sensor_q <= req_i.sensor;
          raw_q[0] <= req_i.raw_x;
          raw_q[1] <= req_i.raw_y;
          raw_q[2] <= req_i.raw_z;
          total_q  <= '0;
          sat_q    <= 1'b0;
        end
      end
      mmcal_pkg::ST_RD_ADDR: rd_vld_q <= vld_q[ram_addr];
      mmcal_pkg::ST_RD_DATA: begin
        max_q[axis_q] <= new_max;
        min_q[axis_q] <= new_min;
        fac_q[axis_q] <= rd_entry.fac;
        d_q[axis_q]   <= new_d;
        total_q       <= total_q + mmcal_pkg::SUM_W'(new_d);
      end
      mmcal_pkg::ST_DIV_INIT: begin
        num_q <= {total_q, 8'd0} + mmcal_pkg::NUM_W'(den3 >> 1);
        den_q <= den3;
        rem_q <= '0;
      end
      mmcal_pkg::ST_DIV: begin
        num_q <= num_nxt;
        rem_q <= rem_nxt;
        if (div_cnt_q == DIV_LAST) begin
          fac_q[axis_q] <= quot_clip ? mmcal_pkg::FAC_CLIP
                                     : num_nxt[mmcal_pkg::DATA_W-1:0];
          if (quot_clip) sat_q <= 1'b1;
        end
      end
      mmcal_pkg::ST_MUL:  prod_q <= prod_d;
      mmcal_pkg::ST_CLIP: begin
        cal_q[axis_q] <= cal_d;
        if (clip_hi || clip_lo) sat_q <= 1'b1;
      end
      mmcal_pkg::ST_DONE: begin
        if (load_out) begin
          out_x_q   <= cal_q[0];
          out_y_q   <= cal_q[1];
          out_z_q   <= cal_q[2];
          out_sat_q <= sat_q;
        end
      end
      default: ;
    endcase
  end

  `MMCAL_ASSERT_NEXT(a_accept_starts_read, req_i.valid && req_i.ready,
                     state_q == mmcal_pkg::ST_RD_ADDR && axis_q == '0,
                     "accepted request did not start the extent read at axis 0")
  `MMCAL_ASSERT_NOW(a_div_den_nonzero, state_q == mmcal_pkg::ST_DIV, den_q != '0,
                    "divider running with a zero divisor")
  `MMCAL_ASSERT_NOW(a_axis_in_range, state_q != mmcal_pkg::ST_IDLE,
                    axis_q <= mmcal_pkg::LAST_AXIS, "axis counter out of range")
  `MMCAL_ASSERT_NEXT(a_clip_last_done,
                     state_q == mmcal_pkg::ST_CLIP && axis_q == mmcal_pkg::LAST_AXIS,
                     state_q == mmcal_pkg::ST_DONE,
                     "last axis did not lead to result hand-over")

endmodule

/* src/mmcal_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mmcal_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
